// File: rtl/palette_tint_nearest_map_assert.svh
// Assertion macros for the palette tint / nearest-match block.
// Used by palette_tint_nearest_map.sv; expects clk and rst_n in scope.
`ifndef PALETTE_TINT_NEAREST_MAP_ASSERT_SVH
`define PALETTE_TINT_NEAREST_MAP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define PTNM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptnm assertion failed");
// Next-cycle implication, disabled while in reset.
`define PTNM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptnm assertion failed");
`else
`define PTNM_ASSERT_IMP(label, ante, cons)
`define PTNM_ASSERT_NXT(label, ante, cons)
`endif

`endif

// File: rtl/ptnm_pkg.sv
// Shared types and constants for the palette tint / nearest-match block.
// No dependencies; imported by every module of the block.
package ptnm_pkg;

  localparam int PAL_SIZE  = 256;
  localparam int PAL_IDX_W = (PAL_SIZE > 1) ? $clog2(PAL_SIZE) : 1;
  localparam logic [8:0] PAL_SIZE_X = 9'(PAL_SIZE);

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [14:0] MAX_DIST = 15'd20000;

  // floor(m / 100) == (m * DIV100_MUL) >> DIV100_SHIFT for m below 32768
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_TINT_RED     = 3'd0,
    REG_TINT_GREEN   = 3'd1,
    REG_TINT_BLUE    = 3'd2,
    REG_TINT_PERCENT = 3'd3,
    REG_KEEP_A       = 3'd4,
    REG_KEEP_B       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] percent;
  } tint_cfg_t;

  // One step of the palette sweep as seen by the distance unit.
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [PAL_IDX_W-1:0] idx;
  } srch_beat_t;

endpackage

// File: rtl/ptnm_cell.sv
// One palette cell of the rotating ring: holds a single RGB entry.
// Depends on ptnm_pkg for rgb_t.
module ptnm_cell
  import ptnm_pkg::*;
(
  input  logic clk,
  input  logic shift,
  input  rgb_t nbr,
  input  logic wr_en,
  input  rgb_t wr_data,
  output rgb_t entry
);

  rgb_t entry_r;

  // Rotation wins; loads only happen while the ring is at rest.
  always_ff @(posedge clk) begin
    if (shift) begin
      entry_r <= nbr;
    end else if (wr_en) begin
      entry_r <= wr_data;
    end
  end

  assign entry = entry_r;

endmodule

// File: rtl/ptnm_tint.sv
// Tint pipeline: brightness term, per-channel tint and wrap to 8 bits.
// Depends on ptnm_pkg; done is start carried through the valid shift register v_r.
module ptnm_tint
  import ptnm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  rgb_t      color_in,
  input  logic      keep,
  input  tint_cfg_t cfg,
  output logic      done,
  output rgb_t      color_out
);

  logic [5:0]        v_r;
  logic [2:0][7:0]   c_r;
  logic              keep_r;
  logic [7:0]        hi_r;
  logic [16:0]       lumprod_r;
  logic [2:0][15:0]  tprod_r;
  logic signed [2:0][15:0] pprod_r;
  logic [2:0][27:0]  qprod_r;
  logic [2:0]        neg_r;
  logic [2:0][7:0]   res_r;

  logic [2:0][7:0]   tc;
  logic [7:0]        hi_nxt;
  logic [8:0]        sumlo_nxt;
  logic [7:0]        lum;

  assign tc = {cfg.red, cfg.green, cfg.blue};

  // Brightest channel; the other two only matter as a sum.
  always_comb begin
    hi_nxt = c_r[2];
    if (c_r[1] > hi_nxt) begin
      hi_nxt = c_r[1];
    end
    if (c_r[0] > hi_nxt) begin
      hi_nxt = c_r[0];
    end
    sumlo_nxt = 9'(10'({2'b0, c_r[2]}) + 10'({2'b0, c_r[1]}) + 10'({2'b0, c_r[0]})
                   - 10'({2'b0, hi_nxt}));
  end

  assign lum = hi_r + lumprod_r[16:9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], start};
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0]       t17;
    logic [7:0]        target;
    logic signed [15:0] diff;
    logic signed [15:0] pct;
    logic [14:0]       mag;
    logic [7:0]        q8;
    if (start) begin
      c_r    <= color_in;
      keep_r <= keep;
    end
    hi_r      <= hi_nxt;
    lumprod_r <= 17'({9'b0, 8'd255 - hi_nxt} * {8'b0, sumlo_nxt});
    for (int k = 0; k < 3; k++) begin
      tprod_r[k] <= {8'b0, lum} * {8'b0, tc[k]};
      // x / 255 for x up to 255*255
      t17    = 17'(tprod_r[k]) + 17'(tprod_r[k][15:8]) + 17'd1;
      target = t17[15:8];
      diff   = 16'(signed'({1'b0, target})) - 16'(signed'({1'b0, c_r[k]}));
      pct    = 16'(signed'({1'b0, cfg.percent}));
      pprod_r[k] <= diff * pct;
      mag    = pprod_r[k][15] ? 15'(-pprod_r[k]) : 15'(pprod_r[k]);
      neg_r[k]   <= pprod_r[k][15];
      qprod_r[k] <= {13'b0, mag} * {15'b0, DIV100_MUL};
      q8     = qprod_r[k][DIV100_SHIFT+7:DIV100_SHIFT];
      if (v_r[4]) begin
        if (keep_r) begin
          res_r[k] <= c_r[k];
        end else if (neg_r[k]) begin
          res_r[k] <= c_r[k] - q8;
        end else begin
          res_r[k] <= c_r[k] + q8;
        end
      end
    end
  end

  assign done      = v_r[5];
  assign color_out = res_r;

endmodule

// File: rtl/ptnm_search.sv
// Distance unit fed by the head of the palette ring; tracks the best match.
// Depends on ptnm_pkg; two-stage pipeline per entry.
module ptnm_search
  import ptnm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  srch_beat_t           beat,
  input  rgb_t                 entry,
  input  rgb_t                 color,
  output logic                 done,
  output logic [PAL_IDX_W-1:0] match
);

  logic                 va_r;
  logic                 lasta_r;
  logic [PAL_IDX_W-1:0] idxa_r;
  logic [2:0][15:0]     sq_r;
  logic [14:0]          best_r;
  logic [PAL_IDX_W-1:0] match_r;
  logic                 done_r;

  logic [2:0][7:0]      a_ch;
  logic [2:0][7:0]      b_ch;
  logic [17:0]          sq_sum;

  assign a_ch   = color;
  assign b_ch   = entry;
  assign sq_sum = 18'(sq_r[2]) + 18'(sq_r[1]) + 18'(sq_r[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      lasta_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      va_r    <= beat.valid;
      lasta_r <= beat.valid && beat.last;
      done_r  <= va_r && lasta_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [8:0] d;
    idxa_r <= beat.idx;
    for (int k = 0; k < 3; k++) begin
      d = signed'({1'b0, a_ch[k]}) - signed'({1'b0, b_ch[k]});
      sq_r[k] <= 16'(d * d);
    end
    // Strict compare keeps the lower index on a tie.
    if (start) begin
      best_r  <= MAX_DIST;
      match_r <= '0;
    end else if (va_r && (sq_sum < 18'(best_r))) begin
      best_r  <= sq_sum[14:0];
      match_r <= idxa_r;
    end
  end

  assign done  = done_r;
  assign match = match_r;

endmodule

// File: rtl/palette_tint_nearest_map.sv
// Top level of the palette tint / nearest-match block: APB registers,
// request control, palette ring, fetch copy, tint pipeline and distance unit.
// Depends on ptnm_pkg, ptnm_cell, ptnm_tint, ptnm_search and the assert header.

// The block stores a palette of PAL_SIZE RGB entries. A load request
// (req_type 0) writes one entry and gives no result. A query request
// (req_type 1) reads the named entry, tints it toward the programmed tint
// color by tint_percent (entries named by keep_index_a/b pass untinted),
// then sweeps the whole palette for the entry with the smallest squared RGB
// distance under 20000, lower index winning a tie, 0 if none is that close.
// A query occupies the block from its accept to the next accept: the accept,
// a step that hands the fetched entry to the tint pipeline, the tint
// pipeline, a sweep in which the ring of palette cells rotates past the
// distance unit one entry per step, the drain of that unit, and the move of
// the result into the output register. Every palette entry must be loaded
// before the first query. Registers sit at byte address 4*i; the user must
// write them only while the block is idle, as the block does not enforce it.
// The result waits in an output register, so a new request is taken while
// the previous result is stalled.
`include "palette_tint_nearest_map_assert.svh"

module palette_tint_nearest_map
  import ptnm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [7:0]            in_entry_index,
  input  logic [7:0]            in_red_in,
  input  logic [7:0]            in_green_in,
  input  logic [7:0]            in_blue_in,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_match_index,
  output logic [7:0]            out_tinted_red,
  output logic [7:0]            out_tinted_green,
  output logic [7:0]            out_tinted_blue
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TINT,
    S_SEARCH,
    S_WAIT,
    S_OUT
  } state_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  tint_cfg_t         cfg_r;
  logic signed [8:0] keep_a_r;
  logic signed [8:0] keep_b_r;
  cfg_reg_t          reg_sel;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r    <= '0;
      keep_a_r <= -9'sd1;
      keep_b_r <= -9'sd1;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_TINT_RED:     cfg_r.red     <= pwdata[7:0];
        REG_TINT_GREEN:   cfg_r.green   <= pwdata[7:0];
        REG_TINT_BLUE:    cfg_r.blue    <= pwdata[7:0];
        REG_TINT_PERCENT: cfg_r.percent <= pwdata[6:0];
        REG_KEEP_A:       keep_a_r      <= signed'(pwdata[8:0]);
        REG_KEEP_B:       keep_b_r      <= signed'(pwdata[8:0]);
        default: ;
      endcase
    end
  end

  // Read back; keep indexes return sign-extended.
  always_comb begin
    unique case (reg_sel)
      REG_TINT_RED:     prdata = CFG_DATA_W'(cfg_r.red);
      REG_TINT_GREEN:   prdata = CFG_DATA_W'(cfg_r.green);
      REG_TINT_BLUE:    prdata = CFG_DATA_W'(cfg_r.blue);
      REG_TINT_PERCENT: prdata = CFG_DATA_W'(cfg_r.percent);
      REG_KEEP_A:       prdata = CFG_DATA_W'(keep_a_r);
      REG_KEEP_B:       prdata = CFG_DATA_W'(keep_b_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request intake
  // ---------------------------------------------------------------------
  state_t               state_r;
  logic [PAL_IDX_W-1:0] cnt_r;
  logic                 tint_start_r;
  logic                 q_in_range_r;
  logic                 q_keep_r;
  logic                 out_valid_r;
  logic [7:0]           out_match_r;
  rgb_t                 out_color_r;

  logic                 in_acc;
  logic                 in_range;
  logic                 load_acc;
  logic                 query_acc;
  logic [PAL_IDX_W-1:0] in_addr;
  rgb_t                 ld_color;
  logic                 keep_hit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_range  = ({1'b0, in_entry_index} < PAL_SIZE_X);
  assign load_acc  = in_acc && (in_req_type == REQ_LOAD) && in_range;
  assign query_acc = in_acc && (in_req_type == REQ_QUERY);
  assign in_addr   = in_entry_index[PAL_IDX_W-1:0];
  assign ld_color  = '{red: in_red_in, green: in_green_in, blue: in_blue_in};
  // Negative keep values have bit 8 set and never match.
  assign keep_hit  = ({1'b0, in_entry_index} == keep_a_r) ||
                     ({1'b0, in_entry_index} == keep_b_r);

  // ---------------------------------------------------------------------
  // Fetch copy of the palette: reads the queried entry into a register on the accept cycle
  // ---------------------------------------------------------------------
  rgb_t fetch_mem [PAL_SIZE];
  rgb_t fetch_r;

  always_ff @(posedge clk) begin
    if (load_acc) begin
      fetch_mem[in_addr] <= ld_color;
    end
    if (in_acc) begin
      fetch_r <= fetch_mem[in_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Palette ring: cell i holds entry i at rest; each search step moves
  // every entry one cell toward cell 0, which feeds the distance unit.
  // PAL_SIZE steps bring the ring back to rest.
  // ---------------------------------------------------------------------
  rgb_t ring [PAL_SIZE];
  logic ring_shift;

  assign ring_shift = (state_r == S_SEARCH);

  for (genvar i = 0; i < PAL_SIZE; i++) begin : g_cell
    ptnm_cell u_cell (
      .clk     (clk),
      .shift   (ring_shift),
      .nbr     (ring[(i + 1) % PAL_SIZE]),
      .wr_en   (load_acc && (in_addr == PAL_IDX_W'(i))),
      .wr_data (ld_color),
      .entry   (ring[i])
    );
  end

  // ---------------------------------------------------------------------
  // Tint pipeline
  // ---------------------------------------------------------------------
  logic tint_done;
  rgb_t tint_color;

  ptnm_tint u_tint (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (tint_start_r),
    .color_in  (q_in_range_r ? fetch_r : rgb_t'('0)),
    .keep      (q_keep_r),
    .cfg       (cfg_r),
    .done      (tint_done),
    .color_out (tint_color)
  );

  // ---------------------------------------------------------------------
  // Distance unit
  // ---------------------------------------------------------------------
  srch_beat_t           beat;
  logic                 srch_done;
  logic [PAL_IDX_W-1:0] srch_match;
  logic                 last_step;

  assign last_step  = (cnt_r == PAL_IDX_W'(PAL_SIZE - 1));
  assign beat.valid = ring_shift;
  assign beat.last  = last_step;
  assign beat.idx   = cnt_r;

  ptnm_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (tint_done),
    .beat  (beat),
    .entry (ring[0]),
    .color (tint_color),
    .done  (srch_done),
    .match (srch_match)
  );

  // ---------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      tint_start_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      tint_start_r <= query_acc;
      unique case (state_r)
        S_IDLE: begin
          if (query_acc) begin
            state_r      <= S_TINT;
            q_in_range_r <= in_range;
            q_keep_r     <= keep_hit;
          end
        end
        S_TINT: begin
          // hold until the tinted color is ready, then start the sweep
          if (tint_done) begin
            state_r <= S_SEARCH;
            cnt_r   <= '0;
          end
        end
        S_SEARCH: begin
          cnt_r <= cnt_r + 1'b1;
          if (last_step) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (srch_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the finished request until the output register frees up
          if (out_free) begin
            state_r     <= S_IDLE;
            out_match_r <= 8'(srch_match);
            out_color_r <= tint_color;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // advance the output register: load a new result or drop a taken one
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_match_index  = out_match_r;
  assign out_tinted_red   = out_color_r.red;
  assign out_tinted_green = out_color_r.green;
  assign out_tinted_blue  = out_color_r.blue;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `PTNM_ASSERT_IMP(a_tint_done_in_tint, tint_done, state_r == S_TINT)
  `PTNM_ASSERT_IMP(a_search_done_in_wait, srch_done, state_r == S_WAIT)
  `PTNM_ASSERT_NXT(a_result_waits, state_r == S_OUT && !out_free, state_r == S_OUT)
  `PTNM_ASSERT_NXT(a_query_starts_tint, query_acc, tint_start_r && state_r == S_TINT)

endmodule

// File: tb/sv/tb_palette_tint_nearest_map.sv
// Self-checking bench for palette_tint_nearest_map: loads and queries go in on
// the request channel, a local tint and nearest-match predictor checks each result.
// Depends on ptnm_pkg and the palette_tint_nearest_map RTL.
module tb_palette_tint_nearest_map;
  import ptnm_pkg::*;

  // Longest run of cycles with no handshake on any port before giving up.
  localparam int STUCK_LIMIT = 20000;
  // Cycles to let the block settle after the last result of a phase.
  localparam int SETTLE_CYCLES = 300;
  // Length of the one long receiver hold-off.
  localparam int LONG_HOLD = 3000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 230;

  typedef struct packed {
    logic       kind;
    logic [7:0] entry;
    rgb_t       color;
  } palette_req_t;

  typedef struct packed {
    logic [7:0] entry;
    rgb_t       color;
  } match_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_req_type = REQ_LOAD;
  logic [7:0]            in_entry_index = '0;
  logic [7:0]            in_red_in = '0;
  logic [7:0]            in_green_in = '0;
  logic [7:0]            in_blue_in = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_match_index;
  logic [7:0]            out_tinted_red;
  logic [7:0]            out_tinted_green;
  logic [7:0]            out_tinted_blue;

  // Shadow of the palette and of the tint registers.
  rgb_t                  palette_model [0:PAL_SIZE-1];
  rgb_t                  tint_rgb = '0;
  logic [6:0]            tint_pct = '0;
  logic signed [8:0]     keep_a = -9'sd1;
  logic signed [8:0]     keep_b = -9'sd1;

  palette_req_t          pending_reqs [$];
  match_t                owed_matches [$];

  bit                    quiet_tail = 1'b0;
  int                    fail_count = 0;
  int                    results_seen = 0;
  int                    feed_gap = 0;
  int                    drain_gap = 0;
  int                    long_hold_left = 0;
  bit                    long_hold_done = 1'b0;
  int                    stuck_cycles = 0;

  palette_tint_nearest_map u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_entry_index   (in_entry_index),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_match_index  (out_match_index),
    .out_tinted_red   (out_tinted_red),
    .out_tinted_green (out_tinted_green),
    .out_tinted_blue  (out_tinted_blue)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Move one channel toward lum*tint/255 by tint_pct percent; both divisions
  // truncate toward zero and the sum wraps to 8 bits.
  function automatic logic [7:0] shade_channel(int c, int lum, int tc);
    int target;
    int delta;
    target = lum * tc / 255;
    delta  = int'(tint_pct) * (target - c) / 100;
    return 8'(c + delta);
  endfunction

  function automatic rgb_t tinted_entry(logic [7:0] idx);
    rgb_t c;
    rgb_t t;
    int   hi, mid, lo, sw, lum, ka, kb;
    c  = palette_model[idx];
    ka = keep_a;
    kb = keep_b;
    // Kept indexes pass untinted; a negative keep index never hits.
    if (ka == int'(idx) || kb == int'(idx)) return c;
    hi  = c.red;
    mid = c.green;
    lo  = c.blue;
    if (hi < mid) begin
      sw = hi; hi = mid; mid = sw;
    end
    if (mid < lo) begin
      sw = mid; mid = lo; lo = sw;
    end
    if (hi < mid) begin
      sw = hi; hi = mid; mid = sw;
    end
    lum     = hi + (255 - hi) * (mid + lo) / 512;
    t.red   = shade_channel(c.red, lum, tint_rgb.red);
    t.green = shade_channel(c.green, lum, tint_rgb.green);
    t.blue  = shade_channel(c.blue, lum, tint_rgb.blue);
    return t;
  endfunction

  // Closest stored entry strictly under the distance bound, lowest index on a
  // tie, 0 when nothing is close enough.
  function automatic logic [7:0] nearest_entry(rgb_t probe);
    int best;
    int dr, dg, db, d;
    logic [7:0] hit;
    best = MAX_DIST;
    hit  = '0;
    for (int i = 0; i < PAL_SIZE; i++) begin
      dr = int'(probe.red) - int'(palette_model[i].red);
      dg = int'(probe.green) - int'(palette_model[i].green);
      db = int'(probe.blue) - int'(palette_model[i].blue);
      d  = dr * dr + dg * dg + db * db;
      if (d < best) begin
        best = d;
        hit  = 8'(i);
      end
    end
    return hit;
  endfunction

  // Apply one accepted request to the shadow palette; queue a result per query.
  function automatic void absorb_request(palette_req_t req);
    match_t m;
    if (req.kind == REQ_LOAD) begin
      palette_model[req.entry] = req.color;
    end else begin
      m.color = tinted_entry(req.entry);
      m.entry = nearest_entry(m.color);
      owed_matches.push_back(m);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: feed pending_reqs onto the input channel with random gaps.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    palette_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_request('{in_req_type, in_entry_index,
                         '{in_red_in, in_green_in, in_blue_in}});
      end
      // Hold the request steady while the block stalls it.
      if (!(in_valid && in_stall)) begin
        if (feed_gap == 0 && !quiet_tail && $urandom_range(0, 9) == 0)
          feed_gap = $urandom_range(1, 6);
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_valid       <= 1'b1;
          in_req_type    <= nxt.kind;
          in_entry_index <= nxt.entry;
          in_red_in      <= nxt.color.red;
          in_green_in    <= nxt.color.green;
          in_blue_in     <= nxt.color.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each result against the oldest owed match, and
  // drive out_stall with short random bursts plus one long hold-off.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    match_t want;
    logic   hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (owed_matches.size() == 0) begin
          $error("result with no query outstanding: match_index %0d", out_match_index);
          fail_count++;
        end else begin
          want = owed_matches.pop_front();
          if (out_match_index !== want.entry) begin
            $error("match_index: expected %0d, got %0d", want.entry, out_match_index);
            fail_count++;
          end
          if (out_tinted_red !== want.color.red) begin
            $error("tinted_red: expected %0d, got %0d", want.color.red, out_tinted_red);
            fail_count++;
          end
          if (out_tinted_green !== want.color.green) begin
            $error("tinted_green: expected %0d, got %0d", want.color.green,
                   out_tinted_green);
            fail_count++;
          end
          if (out_tinted_blue !== want.color.blue) begin
            $error("tinted_blue: expected %0d, got %0d", want.color.blue, out_tinted_blue);
            fail_count++;
          end
        end
      end
      // Back up the block once, long enough that it stalls its input.
      if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        long_hold_left = LONG_HOLD;
      end
      if (long_hold_left > 0) begin
        long_hold_left--;
        hold = 1'b1;
      end else begin
        if (drain_gap == 0 && !quiet_tail && $urandom_range(0, 9) == 0)
          drain_gap = $urandom_range(1, 6);
        hold = 1'b0;
        if (drain_gap > 0) begin
          drain_gap--;
          hold = 1'b1;
        end
      end
      out_stall <= hold;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no port moves for too long.
  // ---------------------------------------------------------------------------
  initial begin
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("FAIL palette_tint_nearest_map");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Register write with a setup and an access phase; update the shadow copy once it lands.
  task automatic write_reg(input cfg_reg_t which, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({which, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (which)
      REG_TINT_RED:     tint_rgb.red   = value[7:0];
      REG_TINT_GREEN:   tint_rgb.green = value[7:0];
      REG_TINT_BLUE:    tint_rgb.blue  = value[7:0];
      REG_TINT_PERCENT: tint_pct       = value[6:0];
      REG_KEEP_A:       keep_a         = value[8:0];
      REG_KEEP_B:       keep_b         = value[8:0];
      default: ;
    endcase
    // Return on the falling edge so queue pushes never race the driver.
    @(negedge clk);
  endtask

  task automatic write_tint(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [6:0] pct);
    write_reg(REG_TINT_RED, 32'(r));
    write_reg(REG_TINT_GREEN, 32'(g));
    write_reg(REG_TINT_BLUE, 32'(b));
    write_reg(REG_TINT_PERCENT, 32'(pct));
  endtask

  task automatic write_keeps(input logic [8:0] ka, input logic [8:0] kb);
    write_reg(REG_KEEP_A, 32'(ka));
    write_reg(REG_KEEP_B, 32'(kb));
  endtask

  function automatic void push_load(logic [7:0] idx, rgb_t color);
    pending_reqs.push_back('{REQ_LOAD, idx, color});
  endfunction

  function automatic void push_query(logic [7:0] idx);
    pending_reqs.push_back('{REQ_QUERY, idx, rgb_t'('0)});
  endfunction

  function automatic rgb_t dark_color();
    return '{8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
             8'($urandom_range(0, 40))};
  endfunction

  function automatic logic [8:0] pick_keep();
    case ($urandom_range(0, 2))
      0:       return 9'h1FF;
      1:       return 9'($urandom_range(0, 255));
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  // Wait until every request is in and every result is out, then let any
  // trailing load drain before touching the registers.
  task automatic settle();
    while (pending_reqs.size() > 0 || in_valid || owed_matches.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int   pick;
    rgb_t color;
    logic [7:0] qidx;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the whole palette first: mostly dark entries, plus a few bright
    // ones placed so that a yellow tint finds nothing within range.
    for (int i = 0; i < PAL_SIZE; i++) begin
      case (i)
        0:       color = '{8'd0, 8'd0, 8'd0};
        7, 200:  color = '{8'd0, 8'd0, 8'd255};
        9:       color = '{8'd255, 8'd0, 8'd0};
        255:     color = '{8'd255, 8'd255, 8'd255};
        default: color = dark_color();
      endcase
      push_load(8'(i), color);
    end

    // Reset settings: no tint, so every query finds its own color; entry 200 ties
    // with entry 7 and must report the lower index.
    push_query(8'd0);
    push_query(8'd7);
    push_query(8'd9);
    push_query(8'd200);
    push_query(8'd255);
    settle();

    // Full yellow tint: bright entries land far from everything, match is 0.
    write_tint(8'd255, 8'd255, 8'd0, 7'd100);
    push_query(8'd7);
    push_query(8'd255);
    push_query(8'd0);
    push_query(8'd9);
    settle();

    // Overshooting percent wraps; both keep indexes pass entries untinted.
    write_tint(8'd255, 8'd255, 8'd255, 7'd127);
    write_keeps(9'd7, 9'd200);
    push_query(8'd7);
    push_query(8'd200);
    push_query(8'd9);
    push_query(8'd255);
    push_query(8'd0);
    settle();

    // Most negative keep index never hits; top index kept.
    write_tint(8'd1, 8'd128, 8'd254, 7'd1);
    write_keeps(9'h100, 9'd255);
    push_query(8'd255);
    push_query(8'd0);
    push_query(8'd9);
    push_query(8'd7);
    settle();

    // Random phases, each under its own register setting; the last one runs
    // with no idling on either side.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES - 1) quiet_tail = 1'b1;
      case (ph)
        1:       write_tint(8'd255, 8'd255, 8'd255, 7'd100);
        2:       write_tint(8'd0, 8'd0, 8'd0, 7'd0);
        default: write_tint(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
      endcase
      write_keeps(pick_keep(), pick_keep());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          // Mix dark entries back in so out-of-range searches keep happening.
          if ($urandom_range(0, 3) == 0) color = dark_color();
          else color = rgb_t'(24'($urandom));
          push_load(8'($urandom_range(0, 255)), color);
        end else begin
          qidx = 8'($urandom_range(0, 255));
          if (pick < 42 && !keep_a[8]) qidx = keep_a[7:0];
          else if (pick < 48 && !keep_b[8]) qidx = keep_b[7:0];
          push_query(qidx);
        end
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("PASS palette_tint_nearest_map");
    end else begin
      $display("FAIL palette_tint_nearest_map");
    end
    $finish;
  end

endmodule
